@@ rtl/core/xmpe_pkg.sv @@
// shared types, encoding constants and nop tables for the mov patch encoder
package xmpe_pkg;

  localparam int unsigned MAX_SLOT_BYTES_DEF = 30;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned HDR_BYTES          = 7;
  localparam int unsigned NOP_MAX            = 9;

  localparam logic [7:0] REX_W        = 8'h48;
  localparam logic [7:0] OPC_MOV_IMM  = 8'hC7;
  localparam logic [7:0] MODRM_REG    = 8'hC0;
  localparam logic [7:0] OPC_MOV_R32  = 8'hB8;
  localparam logic [7:0] OPC_MOV_LOAD = 8'h8B;
  localparam logic [7:0] MODRM_DISP32 = 8'h80;

  localparam logic OP_SINGLE = 1'b0;
  localparam logic OP_PAIR   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_REG = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  // instruction bytes ahead of the padding, byte 0 goes out first
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    status_e                   status;
  } hdr_t;

  // row is the nop length, row nine is the long form used first
  localparam logic [7:0] NOP_TABLE [10][9] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h90, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h90, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0F, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0F, 8'h1F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0F, 8'h1F, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h0F, 8'h1F, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0F, 8'h1F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0F, 8'h1F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h0F, 8'h1F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic [7:0] nop_byte(input logic [3:0] len, input logic [3:0] off);
    logic [7:0] b;
    b = 8'h00;
    if (len <= 4'd9 && off <= 4'd8) begin
      b = NOP_TABLE[len][off];
    end
    return b;
  endfunction

endpackage

@@ rtl/core/x86_mov_patch_encoder.sv @@
// top level of the x86-64 mov patch encoder
//
// one request on the input channel (in_valid_i / in_stall_o) describes a code
// slot to rewrite; the output channel (out_valid_o / out_stall_i) returns the
// replacement bytes one per transfer, last_byte_o marking the final byte.
// the front end classifies a request and computes the instruction bytes in
// the cycle it is taken; a two-entry queue holds classified requests; the
// back end streams instruction bytes then nop padding from an output register.
// the first byte passes through the queue, the sequencer state and the output
// register. throughput: one byte per cycle unless the output stalls, so
// slot_length bytes per request (one for an error), set by the single
// byte-wide output port; the next request is loaded while the last byte of
// the current one goes out. a stalled output holds its byte; the queue keeps
// taking requests until full, then in_stall_o rises.
// reset empties the queue and clears the output valid.
module x86_mov_patch_encoder
  import xmpe_pkg::*;
#(
  parameter int unsigned MAX_SLOT_BYTES = MAX_SLOT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [3:0]  dest_reg_i,
  input  logic        dest_wide_i,
  input  logic [3:0]  base_reg_i,
  input  logic [4:0]  slot_length_i,
  input  logic [31:0] index_value_i,
  input  logic [31:0] displacement_i,
  input  logic [3:0]  scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        last_byte_o,
  output logic [1:0]  patch_status_o
);

  localparam int unsigned LEN_W = $clog2(MAX_SLOT_BYTES + 1);
  localparam int unsigned Q_W   = $bits(hdr_t) + LEN_W;

  hdr_t             f_hdr;
  logic [LEN_W-1:0] f_len;
  logic             f_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_rdata;
  hdr_t             b_hdr;
  logic [LEN_W-1:0] b_len;

  xmpe_front #(
    .MAX_SLOT_BYTES(MAX_SLOT_BYTES),
    .LEN_W         (LEN_W)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .dest_reg_i    (dest_reg_i),
    .dest_wide_i   (dest_wide_i),
    .base_reg_i    (base_reg_i),
    .slot_length_i (slot_length_i),
    .index_value_i (index_value_i),
    .displacement_i(displacement_i),
    .scale_i       (scale_i),
    .q_full_i      (q_full),
    .push_o        (f_push),
    .hdr_o         (f_hdr),
    .len_o         (f_len)
  );

  xmpe_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .wdata_i({f_hdr, f_len}),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  assign b_hdr = hdr_t'(q_rdata[Q_W-1:LEN_W]);
  assign b_len = q_rdata[LEN_W-1:0];

  xmpe_back #(
    .MAX_SLOT_BYTES(MAX_SLOT_BYTES),
    .LEN_W         (LEN_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .hdr_i         (b_hdr),
    .len_i         (b_len),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_byte_o   (code_byte_o),
    .last_byte_o   (last_byte_o),
    .patch_status_o(patch_status_o)
  );

  // an error is a single zero byte
  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && patch_status_o != ST_OK |-> last_byte_o && code_byte_o == 8'h00)
    else $error("error result not a single zero byte");

  // a taken request is queued on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid)
    else $error("accepted request missing from queue");

  // the back end only pulls from a non-empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/xmpe_front.sv @@
// front end: request handshake and classification into instruction header and length
module xmpe_front
  import xmpe_pkg::*;
#(
  parameter int unsigned MAX_SLOT_BYTES = MAX_SLOT_BYTES_DEF,
  parameter int unsigned LEN_W          = $clog2(MAX_SLOT_BYTES + 1)
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [3:0]       dest_reg_i,
  input  logic             dest_wide_i,
  input  logic [3:0]       base_reg_i,
  input  logic [4:0]       slot_length_i,
  input  logic [31:0]      index_value_i,
  input  logic [31:0]      displacement_i,
  input  logic [3:0]       scale_i,
  input  logic             q_full_i,
  output logic             push_o,
  output hdr_t             hdr_o,
  output logic [LEN_W-1:0] len_o
);

  localparam int unsigned CMP_W = (LEN_W > 5) ? LEN_W : 5;

  logic [LEN_W-1:0] len_sat;
  logic [31:0]      disp32;
  logic [7:0]       rex;
  logic [7:0]       modrm;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    if (CMP_W'(slot_length_i) > CMP_W'(MAX_SLOT_BYTES)) begin
      len_sat = LEN_W'(MAX_SLOT_BYTES);
    end else begin
      len_sat = LEN_W'(slot_length_i);
    end
  end

  assign disp32 = (index_value_i * 32'(scale_i)) + displacement_i;
  assign rex    = REX_W | {5'b0, dest_reg_i[3], 1'b0, base_reg_i[3]};
  assign modrm  = MODRM_DISP32 | {2'b0, dest_reg_i[2:0], base_reg_i[2:0]};

  always_comb begin
    hdr_o        = '0;
    hdr_o.status = ST_OK;
    len_o        = len_sat;
    if (operation_i == OP_SINGLE) begin
      if (dest_reg_i[3]) begin
        hdr_o.status = ST_BAD_REG;
      end else if (dest_wide_i) begin
        if (len_sat < LEN_W'(7)) begin
          hdr_o.status = ST_SHORT;
        end else begin
          hdr_o.bytes[0]   = REX_W;
          hdr_o.bytes[1]   = OPC_MOV_IMM;
          hdr_o.bytes[2]   = MODRM_REG | {5'b0, dest_reg_i[2:0]};
          hdr_o.bytes[6:3] = index_value_i;
          hdr_o.count      = 3'd7;
        end
      end else begin
        if (len_sat < LEN_W'(5)) begin
          hdr_o.status = ST_SHORT;
        end else begin
          hdr_o.bytes[0]   = OPC_MOV_R32 | {5'b0, dest_reg_i[2:0]};
          hdr_o.bytes[4:1] = index_value_i;
          hdr_o.count      = 3'd5;
        end
      end
    end else begin
      if (len_sat < LEN_W'(7)) begin
        hdr_o.status = ST_SHORT;
      end else if (base_reg_i[2:0] == 3'd4) begin
        hdr_o.status = ST_BAD_REG;
      end else begin
        hdr_o.bytes[0]   = rex;
        hdr_o.bytes[1]   = OPC_MOV_LOAD;
        hdr_o.bytes[2]   = modrm;
        hdr_o.bytes[6:3] = disp32;
        hdr_o.count      = 3'd7;
      end
    end
    // error gives a single zero byte
    if (hdr_o.status != ST_OK) begin
      hdr_o.bytes = '0;
      hdr_o.count = 3'd1;
      len_o       = LEN_W'(1);
    end
  end

endmodule

@@ rtl/core/xmpe_queue.sv @@
// small fifo between the front end and the byte sequencer
module xmpe_queue
  import xmpe_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic [ADDR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == CNT_W'(DEPTH);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == ADDR_W'(DEPTH - 1)) ? '0 : wptr_q + ADDR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == ADDR_W'(DEPTH - 1)) ? '0 : rptr_q + ADDR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/xmpe_back.sv @@
// back end: byte sequencer for instruction bytes and nop padding, with output register
module xmpe_back
  import xmpe_pkg::*;
#(
  parameter int unsigned MAX_SLOT_BYTES = MAX_SLOT_BYTES_DEF,
  parameter int unsigned LEN_W          = $clog2(MAX_SLOT_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  hdr_t             hdr_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       code_byte_o,
  output logic             last_byte_o,
  output logic [1:0]       patch_status_o
);

  localparam int unsigned CMP_W = (LEN_W > 4) ? LEN_W : 4;

  logic             active_q, active_d;
  hdr_t             hdr_q, hdr_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [2:0]       idx_q, idx_d;
  logic [3:0]       off_q, off_d;
  logic [3:0]       nlen_q, nlen_d;
  logic             valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  status_e          status_q;

  logic             out_ready;
  logic             emit;
  logic             in_hdr;
  logic [3:0]       fresh_len;
  logic [3:0]       eff_len;
  logic [7:0]       cur_byte;
  logic             cur_last;

  assign out_ready = !valid_q || !out_stall_i;
  assign emit      = active_q && out_ready;
  assign in_hdr    = idx_q < hdr_q.count;
  assign fresh_len = (CMP_W'(left_q) >= CMP_W'(NOP_MAX)) ? 4'(NOP_MAX) : 4'(left_q);
  assign eff_len   = (off_q == 4'd0) ? fresh_len : nlen_q;
  assign cur_byte  = in_hdr ? hdr_q.bytes[idx_q] : nop_byte(eff_len, off_q);
  assign cur_last  = left_q == LEN_W'(1);
  assign pop_o     = q_valid_i && (!active_q || (emit && cur_last));

  always_comb begin
    active_d = active_q;
    hdr_d    = hdr_q;
    left_d   = left_q;
    idx_d    = idx_q;
    off_d    = off_q;
    nlen_d   = nlen_q;
    if (emit) begin
      left_d = left_q - LEN_W'(1);
      if (in_hdr) begin
        idx_d = idx_q + 3'd1;
      end else begin
        nlen_d = eff_len;
        off_d  = (off_q + 4'd1 == eff_len) ? 4'd0 : off_q + 4'd1;
      end
      if (cur_last) begin
        active_d = 1'b0;
      end
    end
    if (pop_o) begin
      active_d = 1'b1;
      hdr_d    = hdr_i;
      left_d   = len_i;
      idx_d    = '0;
      off_d    = '0;
      nlen_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      left_q   <= '0;
      idx_q    <= '0;
      off_q    <= '0;
      nlen_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      off_q    <= off_d;
      nlen_q   <= nlen_d;
      if (out_ready) begin
        valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (emit) begin
      byte_q   <= cur_byte;
      last_q   <= cur_last;
      status_q <= hdr_q.status;
    end
  end

  assign out_valid_o    = valid_q;
  assign code_byte_o    = byte_q;
  assign last_byte_o    = last_q;
  assign patch_status_o = status_q;

endmodule
